// ===== hw/rtl/phantom_harmonic_generator_macros.svh =====
// assertion macros shared by the phantom harmonic generator rtl
`ifndef PHANTOM_HARMONIC_GENERATOR_MACROS_SVH
`define PHANTOM_HARMONIC_GENERATOR_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define PHG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("phg: same-cycle check failed");

// next-cycle implication
`define PHG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("phg: next-cycle check failed");

`endif

// ===== hw/rtl/phg_pkg.sv =====
// types, widths and constants of the phantom harmonic generator
package phg_pkg;

   localparam int NUM_HARMONICS = 10;

   localparam int SRC_W      = 17;
   localparam int AMP_W      = 16;
   localparam int LIMIT_W    = 16;
   localparam int DECAY_W    = 14;
   localparam int MAXF_W     = 17;
   localparam int OUT_FREQ_W = 21;
   localparam int IDX_W      = 4;
   localparam int CSR_W      = 17;
   localparam int CSR_IDX_W  = 2;

   localparam int STEP_W     = SRC_W + 1;
   localparam int FREQ_W     = SRC_W + $clog2(2 * NUM_HARMONICS + 3);
   localparam int FREQ_CMP_W = (FREQ_W > OUT_FREQ_W) ? FREQ_W : OUT_FREQ_W;
   localparam int K_W        = (NUM_HARMONICS > 1) ? $clog2(NUM_HARMONICS) : 1;
   localparam int WAMP_W     = AMP_W + 1;

   localparam int MAX_HALVINGS = 18;
   localparam int HALV_W       = $clog2(MAX_HALVINGS + 1);
   localparam int LIM_SH_W     = LIMIT_W + MAX_HALVINGS;

   localparam int RATIO_FRAC = 30;
   localparam int LOG_FRAC   = 16;
   localparam int X_W        = RATIO_FRAC + 1;
   localparam int PROD_W     = 2 * X_W;
   localparam int CNT_W      = $clog2(RATIO_FRAC);

   localparam logic [OUT_FREQ_W-1:0] FREQ_OUT_MAX = '1;
   localparam logic signed [WAMP_W-1:0] AMP_MIN = -WAMP_W'(32768);

   localparam logic [LIMIT_W-1:0] PHANTOM_LIMIT_RESET   = LIMIT_W'(5120);
   localparam logic [DECAY_W-1:0] DECAY_DB_RESET        = DECAY_W'(6144);
   localparam logic [MAXF_W-1:0]  MAX_SOURCE_FREQ_RESET = MAXF_W'(64000);

   localparam logic [CSR_IDX_W-1:0] CSR_PHANTOM_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_DB        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SOURCE_FREQ = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HALVE,
      ST_EMIT,
      ST_OCTAVE
   } top_state_type;

   typedef enum logic [1:0] {
      OU_IDLE,
      OU_DIV,
      OU_SQUARE,
      OU_SCALE
   } oct_state_type;

   typedef struct packed {
      logic              start;
      logic [FREQ_W-1:0] freq;
      logic [STEP_W-1:0] step;
   } oct_cmd_type;

   typedef struct packed {
      logic               done;
      logic [DECAY_W-1:0] dec;
   } oct_status_type;

endpackage

// ===== hw/rtl/phantom_harmonic_generator.sv =====
// Phantom harmonic generator: takes the lowest partial of a frame and emits a run of
// NUM_HARMONICS partials at source + (k+1)*step, each lowered by decay_db times its octave
// distance from the one before. Beats with no partial, a zero frequency or a frequency
// above max_source_freq are accepted and give nothing. An accepted partial first finds the
// step (one halving compare per cycle), then for each harmonic but the last runs a bit-serial
// divide for the frequency ratio, repeated squaring for its log2 and a scaling step on the
// shared multiplier. The block takes a new beat only when the previous run is finished; the
// last result may still wait in the output register. Configuration writes take effect at
// once and belong in idle periods.
`include "phantom_harmonic_generator_macros.svh"

module phantom_harmonic_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_valid_req,
   input  logic [phg_pkg::SRC_W-1:0]            req_source_freq,
   input  logic signed [phg_pkg::AMP_W-1:0]     req_source_amp_db,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [phg_pkg::OUT_FREQ_W-1:0]       rsp_harmonic_freq,
   output logic signed [phg_pkg::AMP_W-1:0]     rsp_harmonic_amp_db,
   output logic [phg_pkg::IDX_W-1:0]            rsp_harmonic_index,
   output logic                                 rsp_last,
   input  logic                                 csr_we,
   input  logic [phg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [phg_pkg::CSR_W-1:0]            csr_wdata
);
   import phg_pkg::*;

   logic [LIMIT_W-1:0]        limit_ff;
   logic [DECAY_W-1:0]        decay_ff;
   logic [MAXF_W-1:0]         maxf_ff;

   top_state_type             state_ff, state_in;
   logic [SRC_W-1:0]          src_ff, src_in;
   logic [LIM_SH_W-1:0]       lim_sh_ff, lim_sh_in;
   logic [HALV_W-1:0]         halv_ff, halv_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [FREQ_W-1:0]         freq_ff, freq_in;
   logic signed [WAMP_W-1:0]  amp_ff, amp_in;
   logic [K_W-1:0]            k_ff, k_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUT_FREQ_W-1:0]     rsp_freq_ff, rsp_freq_in;
   logic signed [AMP_W-1:0]   rsp_amp_ff, rsp_amp_in;
   logic [IDX_W-1:0]          rsp_index_ff, rsp_index_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      req_fire;
   logic                      rsp_load;
   logic                      is_last;
   logic signed [WAMP_W-1:0]  amp_diff;
   oct_cmd_type               oct_cmd;
   oct_status_type            oct_status;

   phg_octave_unit u_octave (
      .clock  (clock),
      .reset  (reset),
      .cmd    (oct_cmd),
      .decay  (decay_ff),
      .status (oct_status)
   );

   // configuration registers, only the stated width of each is kept
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= PHANTOM_LIMIT_RESET;
         decay_ff <= DECAY_DB_RESET;
         maxf_ff  <= MAX_SOURCE_FREQ_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PHANTOM_LIMIT:   limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_DECAY_DB:        decay_ff <= csr_wdata[DECAY_W-1:0];
            CSR_MAX_SOURCE_FREQ: maxf_ff  <= csr_wdata[MAXF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign is_last   = (k_ff == K_W'(NUM_HARMONICS - 1));
   assign rsp_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign amp_diff  = amp_ff - $signed(WAMP_W'(oct_status.dec));

   assign oct_cmd.start = rsp_load && !is_last;
   assign oct_cmd.freq  = freq_ff;
   assign oct_cmd.step  = step_ff;

   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      lim_sh_in    = lim_sh_ff;
      halv_in      = halv_ff;
      step_in      = step_ff;
      freq_in      = freq_ff;
      amp_in       = amp_ff;
      k_in         = k_ff;
      rsp_freq_in  = rsp_freq_ff;
      rsp_amp_in   = rsp_amp_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_valid_req && (req_source_freq != '0) &&
                (MAXF_W'(req_source_freq) <= maxf_ff)) begin
               src_in    = req_source_freq;
               amp_in    = WAMP_W'(req_source_amp_db);
               lim_sh_in = LIM_SH_W'(limit_ff);
               halv_in   = '0;
               step_in   = {req_source_freq, 1'b0};
               state_in  = ST_HALVE;
            end
         end
         ST_HALVE: begin
            // each halving doubles the ceiling and halves twice the source
            if ((halv_ff < HALV_W'(MAX_HALVINGS)) && (LIM_SH_W'(src_ff) > lim_sh_ff)) begin
               halv_in   = halv_ff + HALV_W'(1);
               lim_sh_in = lim_sh_ff << 1;
               step_in   = step_ff >> 1;
            end else begin
               freq_in  = FREQ_W'(src_ff) + FREQ_W'(step_ff);
               k_in     = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_freq_in  = (FREQ_CMP_W'(freq_ff) > FREQ_CMP_W'(FREQ_OUT_MAX)) ?
                              FREQ_OUT_MAX : OUT_FREQ_W'(freq_ff);
               rsp_amp_in   = amp_ff[AMP_W-1:0];
               rsp_index_in = IDX_W'(k_ff);
               rsp_last_in  = is_last;
               state_in     = is_last ? ST_IDLE : ST_OCTAVE;
            end
         end
         ST_OCTAVE: begin
            if (oct_status.done) begin
               amp_in   = (amp_diff < AMP_MIN) ? AMP_MIN : amp_diff;
               freq_in  = freq_ff + FREQ_W'(step_ff);
               k_in     = k_ff + K_W'(1);
               state_in = ST_EMIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      lim_sh_ff    <= lim_sh_in;
      halv_ff      <= halv_in;
      step_ff      <= step_in;
      freq_ff      <= freq_in;
      amp_ff       <= amp_in;
      k_ff         <= k_in;
      rsp_freq_ff  <= rsp_freq_in;
      rsp_amp_ff   <= rsp_amp_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_harmonic_freq   = rsp_freq_ff;
   assign rsp_harmonic_amp_db = rsp_amp_ff;
   assign rsp_harmonic_index  = rsp_index_ff;
   assign rsp_last            = rsp_last_ff;

   `PHG_ASSERT_SAME(a_done_only_when_waiting, clock, reset, oct_status.done, state_ff == ST_OCTAVE)
   `PHG_ASSERT_SAME(a_last_beat_index, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_index_ff == IDX_W'(NUM_HARMONICS - 1))

endmodule

// ===== hw/rtl/phg_octave_unit.sv =====
// octave loss unit: bit-serial ratio divide, log2 by squaring, scale by decay
`include "phantom_harmonic_generator_macros.svh"

module phg_octave_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  phg_pkg::oct_cmd_type         cmd,
   input  logic [phg_pkg::DECAY_W-1:0]  decay,
   output phg_pkg::oct_status_type      status
);
   import phg_pkg::*;

   oct_state_type       state_ff, state_in;
   logic [FREQ_W-1:0]   den_ff, den_in;
   logic [FREQ_W-1:0]   rem_ff, rem_in;
   logic [X_W-1:0]      quo_ff, quo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [LOG_FRAC-1:0] res_ff, res_in;
   logic [DECAY_W-1:0]  dec_ff, dec_in;
   logic                done_ff, done_in;

   logic [FREQ_W:0]     rem_dbl;
   logic [FREQ_W:0]     rem_sub;
   logic                div_bit;
   logic [X_W-1:0]      mul_a, mul_b;
   logic [PROD_W-1:0]   prod;
   logic [PROD_W-1:0]   prod_rnd;

   // the one multiplier, shared by the squaring loop and the decay scaling
   always_comb begin
      unique case (state_ff)
         OU_SQUARE: begin
            mul_a = quo_ff;
            mul_b = quo_ff;
         end
         OU_SCALE: begin
            mul_a = X_W'(decay);
            mul_b = X_W'(res_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod_rnd = prod + (PROD_W'(1) << (LOG_FRAC - 1));
   assign rem_dbl  = {rem_ff, 1'b0};
   assign rem_sub  = rem_dbl - {1'b0, den_ff};
   assign div_bit  = (rem_dbl >= {1'b0, den_ff});

   always_comb begin
      state_in = state_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      dec_in   = dec_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         OU_IDLE: begin
            if (cmd.start) begin
               // ratio is (freq+step)/freq; its integer bit is always one
               den_in   = cmd.freq;
               rem_in   = FREQ_W'(cmd.step);
               quo_in   = X_W'(1);
               cnt_in   = '0;
               state_in = OU_DIV;
            end
         end
         OU_DIV: begin
            rem_in = div_bit ? rem_sub[FREQ_W-1:0] : rem_dbl[FREQ_W-1:0];
            quo_in = {quo_ff[X_W-2:0], div_bit};
            if (cnt_ff == CNT_W'(RATIO_FRAC - 1)) begin
               cnt_in   = '0;
               res_in   = '0;
               state_in = OU_SQUARE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         OU_SQUARE: begin
            // square reaching two gives a one bit and a halving
            quo_in = prod[PROD_W-1] ? prod[PROD_W-1 -: X_W] : prod[PROD_W-2 -: X_W];
            res_in = {res_ff[LOG_FRAC-2:0], prod[PROD_W-1]};
            if (cnt_ff == CNT_W'(LOG_FRAC - 1)) begin
               cnt_in   = '0;
               state_in = OU_SCALE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         OU_SCALE: begin
            dec_in   = prod_rnd[LOG_FRAC +: DECAY_W];
            done_in  = 1'b1;
            state_in = OU_IDLE;
         end
         default: begin
            state_in = OU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
      dec_ff <= dec_in;
   end

   assign status.done = done_ff;
   assign status.dec  = dec_ff;

   `PHG_ASSERT_NEXT(a_start_begins_divide, clock, reset, cmd.start, state_ff == OU_DIV)
   `PHG_ASSERT_SAME(a_loss_within_decay, clock, reset, done_ff, dec_ff <= decay)

endmodule

// ===== dv/phantom_harmonic_generator_test.sv =====
// self-checking testbench for the phantom harmonic generator with its own harmonic predictor
module phantom_harmonic_generator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [phg_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 32;
   localparam int MAX_IDLE = 12;

   typedef struct {
      bit                 has_partial;
      logic [16:0]        freq;
      logic signed [15:0] amp;
      int                 gap;
   } partial_type;

   typedef struct {
      logic [20:0]        freq;
      logic signed [15:0] amp;
      logic [3:0]         idx;
      logic               last;
   } harmonic_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic                                 req_valid_req;
   logic [phg_pkg::SRC_W-1:0]            req_source_freq;
   logic signed [phg_pkg::AMP_W-1:0]     req_source_amp_db;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic [phg_pkg::OUT_FREQ_W-1:0]       rsp_harmonic_freq;
   logic signed [phg_pkg::AMP_W-1:0]     rsp_harmonic_amp_db;
   logic [phg_pkg::IDX_W-1:0]            rsp_harmonic_index;
   logic                                 rsp_last;
   logic                                 csr_we;
   logic [phg_pkg::CSR_IDX_W-1:0]        csr_index;
   logic [phg_pkg::CSR_W-1:0]            csr_wdata;

   partial_type  partial_q[$];
   harmonic_type harmonics_due[$];

   logic [phg_pkg::LIMIT_W-1:0] limit_cfg;
   logic [phg_pkg::DECAY_W-1:0] decay_cfg;
   logic [phg_pkg::MAXF_W-1:0]  maxf_cfg;

   bit req_beat_seen;
   bit rsp_beat_seen;
   bit req_busy;
   bit steady;
   int gap_count;
   int rsp_hold;
   int fail_count;

   phantom_harmonic_generator dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_valid_req       (req_valid_req),
      .req_source_freq     (req_source_freq),
      .req_source_amp_db   (req_source_amp_db),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_harmonic_freq   (rsp_harmonic_freq),
      .rsp_harmonic_amp_db (rsp_harmonic_amp_db),
      .rsp_harmonic_index  (rsp_harmonic_index),
      .rsp_last            (rsp_last),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // log2(upper/lower) in Q.16 by repeated squaring of a Q2.30 ratio
   function automatic longint unsigned octave_frac(longint unsigned upper,
                                                   longint unsigned lower);
      longint unsigned ratio;
      longint unsigned bits;
      ratio = (upper << phg_pkg::RATIO_FRAC) / lower;
      bits = 0;
      for (int i = 0; i < phg_pkg::LOG_FRAC; i++) begin
         ratio = (ratio * ratio) >> phg_pkg::RATIO_FRAC;
         bits = bits << 1;
         if (ratio >= (64'd2 << phg_pkg::RATIO_FRAC)) begin
            bits = bits | 64'd1;
            ratio = ratio >> 1;
         end
      end
      return bits;
   endfunction

   function automatic void derive_harmonics(bit has_partial, logic [16:0] src,
                                            logic signed [15:0] src_amp);
      longint unsigned halvings;
      longint unsigned step;
      longint unsigned freq;
      longint unsigned drop;
      longint          level;
      harmonic_type    h;
      if (!has_partial || src == 0 || src > maxf_cfg)
         return;
      halvings = 0;
      while (halvings < phg_pkg::MAX_HALVINGS && 64'(src) > (64'(limit_cfg) << halvings))
         halvings++;
      step = (64'(src) * 2) >> halvings;
      freq = 64'(src) + step;
      level = src_amp;
      for (int k = 0; k < phg_pkg::NUM_HARMONICS; k++) begin
         h.freq = (freq > 64'(phg_pkg::FREQ_OUT_MAX)) ? phg_pkg::FREQ_OUT_MAX : freq[20:0];
         h.amp  = level[15:0];
         h.idx  = 4'(k);
         h.last = (k == phg_pkg::NUM_HARMONICS - 1);
         harmonics_due = {harmonics_due, h};
         // amplitude uses the unsaturated frequency
         drop = (64'(decay_cfg) * octave_frac(freq + step, freq) + (64'd1 << 15)) >> 16;
         level = level - longint'(drop);
         if (level < -32768)
            level = -32768;
         freq = freq + step;
      end
   endfunction

   // request driver: one beat at a time, gap drawn per beat when queued
   always @(negedge clock) begin : drive_partials
      partial_type next_partial;
      if (!reset) begin
         if (!req_valid || req_beat_seen) begin
            req_busy = 1'b0;
            if (partial_q.size() > 0 && gap_count >= partial_q[0].gap) begin
               next_partial = partial_q.pop_front();
               req_valid         <= 1'b1;
               req_valid_req     <= next_partial.has_partial;
               req_source_freq   <= next_partial.freq;
               req_source_amp_db <= next_partial.amp;
               req_busy = 1'b1;
               gap_count = 0;
            end else begin
               req_valid <= 1'b0;
               if (partial_q.size() > 0)
                  gap_count++;
            end
         end
      end
   end

   // result side back-pressure, a fresh stall drawn after each beat
   always @(negedge clock) begin
      if (rsp_beat_seen)
         rsp_hold = steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : watch_harmonics
      harmonic_type want;
      req_beat_seen <= !reset && req_valid && req_ready;
      rsp_beat_seen <= !reset && rsp_valid && rsp_ready;
      if (!reset && req_valid && req_ready)
         derive_harmonics(req_valid_req, req_source_freq, req_source_amp_db);
      if (!reset && rsp_valid && rsp_ready) begin
         if (harmonics_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected harmonic: freq %0d amp %0d index %0d last %0b",
                        rsp_harmonic_freq, rsp_harmonic_amp_db, rsp_harmonic_index,
                        rsp_last);
         end else begin
            want = harmonics_due.pop_front();
            if (rsp_harmonic_freq !== want.freq || rsp_harmonic_amp_db !== want.amp ||
                rsp_harmonic_index !== want.idx || rsp_last !== want.last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("harmonic mismatch (exp/got): freq %0d/%0d amp %0d/%0d index %0d/%0d last %0b/%0b",
                           want.freq, rsp_harmonic_freq, want.amp, rsp_harmonic_amp_db,
                           want.idx, rsp_harmonic_index, want.last, rsp_last);
            end
         end
      end
   end

   task automatic queue_partial(bit has_partial, logic [16:0] freq, logic signed [15:0] amp);
      partial_type p;
      p.has_partial = has_partial;
      p.freq = freq;
      p.amp = amp;
      p.gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
      partial_q = {partial_q, p};
   endtask

   task automatic queue_random_partials(int count);
      logic [16:0]        freq;
      logic signed [15:0] amp;
      int unsigned        base;
      int                 pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6 && maxf_cfg != 0) begin
            freq = 17'($urandom_range(1, maxf_cfg));
         end else if (pick < 8) begin
            // near a halving boundary
            base = int'(limit_cfg) << $urandom_range(0, 8);
            freq = 17'(base + $urandom_range(0, 2) - 1);
         end else if (pick == 8) begin
            freq = 17'($urandom_range(0, 2));
         end else begin
            freq = 17'($urandom);
         end
         case ($urandom_range(0, 3))
            0: amp = 16'($urandom);
            1: amp = 16'sh8000 + 16'($urandom_range(0, 255));
            2: amp = 16'sh7fff - 16'($urandom_range(0, 255));
            default: amp = 16'($urandom_range(0, 4096)) - 16'sd2048;
         endcase
         queue_partial($urandom_range(0, 9) != 0, freq, amp);
      end
   endtask

   task automatic write_csr(logic [phg_pkg::CSR_IDX_W-1:0] idx, logic [phg_pkg::CSR_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         phg_pkg::CSR_PHANTOM_LIMIT:   limit_cfg = data[phg_pkg::LIMIT_W-1:0];
         phg_pkg::CSR_DECAY_DB:        decay_cfg = data[phg_pkg::DECAY_W-1:0];
         phg_pkg::CSR_MAX_SOURCE_FREQ: maxf_cfg  = data[phg_pkg::MAXF_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // wait for the block to go quiet: nothing queued, in flight or outstanding
   task automatic settle();
      while (partial_q.size() != 0 || req_busy || harmonics_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_valid_req = 1'b0;
      req_source_freq = '0;
      req_source_amp_db = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      limit_cfg = phg_pkg::PHANTOM_LIMIT_RESET;
      decay_cfg = phg_pkg::DECAY_DB_RESET;
      maxf_cfg = phg_pkg::MAX_SOURCE_FREQ_RESET;
      steady = 1'b0;
      gap_count = 0;
      rsp_hold = 0;
      fail_count = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // reset settings: gating cases and the halving boundary
      queue_partial(1'b0, 17'd1000, 16'sd0);
      queue_partial(1'b1, 17'd0, 16'sd100);
      queue_partial(1'b1, 17'd64000, 16'sd0);
      queue_partial(1'b1, 17'd64001, 16'sd0);
      queue_partial(1'b1, 17'd1, 16'sh7fff);
      queue_partial(1'b1, 17'd5120, 16'sh8000);
      queue_partial(1'b1, 17'd5121, 16'sd1234);
      queue_partial(1'b0, 17'h1ffff, -16'sd1);
      settle();

      // steep decay drives the amplitude into saturation
      write_csr(phg_pkg::CSR_PHANTOM_LIMIT, 17'd64000);
      write_csr(phg_pkg::CSR_DECAY_DB, 17'd12288);
      write_csr(phg_pkg::CSR_MAX_SOURCE_FREQ, 17'd128000);
      queue_partial(1'b1, 17'd128000, -16'sd32000);
      queue_partial(1'b1, 17'd64000, 16'sh7fff);
      queue_partial(1'b1, 17'd64001, 16'sh8000);
      queue_partial(1'b1, 17'd3, -16'sd20000);
      queue_random_partials(30);
      settle();

      // zero limit gives a zero step; upper write bits are dropped
      write_csr(phg_pkg::CSR_PHANTOM_LIMIT, 17'd0);
      write_csr(phg_pkg::CSR_DECAY_DB, 17'h1ffff);
      write_csr(phg_pkg::CSR_MAX_SOURCE_FREQ, 17'h1ffff);
      queue_partial(1'b1, 17'h1ffff, 16'sh7fff);
      queue_partial(1'b1, 17'd1, 16'sh8000);
      queue_partial(1'b1, 17'd65536, 16'sd0);
      queue_random_partials(20);
      settle();

      // zero cut-off: every beat is dropped
      write_csr(phg_pkg::CSR_PHANTOM_LIMIT, 17'h1ffff);
      write_csr(phg_pkg::CSR_DECAY_DB, 17'd0);
      write_csr(phg_pkg::CSR_MAX_SOURCE_FREQ, 17'd0);
      write_csr(CSR_SPARE, 17'h15555);
      queue_partial(1'b1, 17'd1, 16'sd5);
      queue_partial(1'b1, 17'd0, 16'sd5);
      queue_random_partials(10);
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 0) begin
            write_csr(phg_pkg::CSR_PHANTOM_LIMIT, 17'd256);
            write_csr(phg_pkg::CSR_DECAY_DB, 17'd12288);
            write_csr(phg_pkg::CSR_MAX_SOURCE_FREQ, 17'd128000);
         end else begin
            write_csr(phg_pkg::CSR_PHANTOM_LIMIT, 17'($urandom_range(256, 64000)));
            write_csr(phg_pkg::CSR_DECAY_DB, 17'($urandom_range(0, 12288)));
            write_csr(phg_pkg::CSR_MAX_SOURCE_FREQ, 17'($urandom_range(1000, 128000)));
         end
         // one phase runs back to back on both sides
         steady = (phase == 2);
         queue_random_partials(30);
         settle();
         steady = 1'b0;
      end

      if (fail_count == 0 && harmonics_due.size() == 0)
         $display("[phantom_harmonic_generator] OK");
      else
         $display("[phantom_harmonic_generator] ERROR");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("[phantom_harmonic_generator] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/phg_pkg.sv
hw/rtl/phg_octave_unit.sv
hw/rtl/phantom_harmonic_generator.sv
dv/phantom_harmonic_generator_test.sv
